@@ hdl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/bva_pkg.sv @@
package bva_pkg;

    localparam int SENSE_W = 12;
    localparam int DATA_W  = 16;
    localparam int CFG_IDX_W = 3;

    // reading times gain, 4095 * 65535 fits in 28 bits
    localparam int PROD_W = SENSE_W + DATA_W;

    // divide by 1000 as multiply by ceil(2^38 / 1000) and shift by 38
    localparam int SCALE_SHIFT = PROD_W + 10;
    localparam int SCALE_RECIP_W = PROD_W + 1;
    localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = 29'd274877907;
    localparam int QUOT_W = PROD_W + SCALE_RECIP_W - SCALE_SHIFT;

    localparam logic [DATA_W-1:0] NOMINAL_MV = 16'd12600;

    localparam logic [DATA_W-1:0] GAIN_RST     = 16'd5700;
    localparam logic [DATA_W-1:0] COMFORT_RST  = 16'd12000;
    localparam logic [DATA_W-1:0] DRIVING_RST  = 16'd11500;
    localparam logic [DATA_W-1:0] CRANK_RST    = 16'd10500;
    localparam logic [DATA_W-1:0] OVERVOLT_RST = 16'd15500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN     = 3'd0,
        CFG_COMFORT  = 3'd1,
        CFG_DRIVING  = 3'd2,
        CFG_CRANK    = 3'd3,
        CFG_OVERVOLT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] comfort;
        logic [DATA_W-1:0] driving;
        logic [DATA_W-1:0] crank;
        logic [DATA_W-1:0] overvolt;
    } t_thresh;

endpackage

@@ hdl/bva_scale.sv @@
module bva_scale
    import bva_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SENSE_W-1:0] i_sense_mv,
    input  logic [DATA_W-1:0] i_gain,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_scaled
);

    logic                 r_a_v, r_b_v, r_c_v;
    logic [SENSE_W-1:0]   r_a_mv;
    logic [PROD_W-1:0]    r_b_prod;
    logic [QUOT_W-1:0]    r_c_quot;
    logic                 adv_a, adv_b, adv_c;
    logic [PROD_W-1:0]    n_prod;
    logic [PROD_W+SCALE_RECIP_W-1:0] n_quot_full;

    assign adv_c = !r_c_v || i_ready;
    assign adv_b = !r_b_v || adv_c;
    assign adv_a = !r_a_v || adv_b;
    assign o_ready = adv_a;

    assign n_prod = PROD_W'(r_a_mv) * PROD_W'(i_gain);
    assign n_quot_full = (PROD_W+SCALE_RECIP_W)'(r_b_prod)
                       * (PROD_W+SCALE_RECIP_W)'(SCALE_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (adv_a) r_a_v <= i_valid;
            if (adv_b) r_b_v <= r_a_v;
            if (adv_c) r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_valid) r_a_mv   <= i_sense_mv;
        if (adv_b && r_a_v)   r_b_prod <= n_prod;
        if (adv_c && r_b_v)   r_c_quot <= n_quot_full[SCALE_SHIFT +: QUOT_W];
    end

    // clamp to 16 bits
    assign o_scaled = (|r_c_quot[QUOT_W-1:DATA_W]) ? {DATA_W{1'b1}} : r_c_quot[DATA_W-1:0];
    assign o_valid  = r_c_v;

endmodule

@@ hdl/bva_window.sv @@
module bva_window
    import bva_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_scaled,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_avg
);

    localparam int L    = $clog2(WINDOW);
    localparam int SUMW = DATA_W + L;
    localparam int SH   = SUMW + L;
    localparam int MW   = SUMW + 1;
    localparam int PW   = SUMW + MW;
    // exact truncating divide by WINDOW over any SUMW-bit sum
    localparam longint unsigned MAVG_L = ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [MW-1:0] MAVG = MW'(MAVG_L);
    localparam logic [SUMW-1:0] SUM_RST = SUMW'(WINDOW) * SUMW'(NOMINAL_MV);

    logic [DATA_W-1:0] r_ring [WINDOW];
    logic [SUMW-1:0]   r_sum;
    logic              r_d_v, r_e_v;
    logic [DATA_W-1:0] r_e_avg;
    logic              adv_d, adv_e;
    logic [SUMW-1:0]   n_sum;
    logic [PW-1:0]     n_avg_prod;

    assign adv_e   = !r_e_v || i_ready;
    assign adv_d   = !r_d_v || adv_e;
    assign o_ready = adv_d;

    // newest enters at the head, the oldest leaves from the tail
    assign n_sum = r_sum - SUMW'(r_ring[WINDOW-1]) + SUMW'(i_scaled);
    assign n_avg_prod = PW'(r_sum) * PW'(MAVG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_sum <= SUM_RST;
            for (int k = 0; k < WINDOW; k++) begin
                r_ring[k] <= NOMINAL_MV;
            end
        end else begin
            if (adv_d) r_d_v <= i_valid;
            if (adv_e) r_e_v <= r_d_v;
            if (adv_d && i_valid) begin
                r_sum     <= n_sum;
                r_ring[0] <= i_scaled;
                for (int k = 1; k < WINDOW; k++) begin
                    r_ring[k] <= r_ring[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_e && r_d_v) r_e_avg <= n_avg_prod[SH +: DATA_W];
    end

    assign o_valid = r_e_v;
    assign o_avg   = r_e_avg;

endmodule

@@ hdl/bva_flags.sv @@
module bva_flags
    import bva_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_avg,
    input  t_thresh           i_thresh,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_avg,
    output logic              o_low_comfort,
    output logic              o_low_driving,
    output logic              o_crank_dip,
    output logic              o_over_voltage
);

    logic              r_f_v;
    logic [DATA_W-1:0] r_avg;
    logic              r_low_comfort, r_low_driving, r_crank_dip, r_over_voltage;
    logic              adv_f;

    assign adv_f   = !r_f_v || i_ready;
    assign o_ready = adv_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (adv_f) begin
            r_f_v <= i_valid;
        end
    end

    // strict compares: equal to a threshold raises nothing
    always_ff @(posedge i_clk) begin
        if (adv_f && i_valid) begin
            r_avg          <= i_avg;
            r_low_comfort  <= i_avg < i_thresh.comfort;
            r_low_driving  <= i_avg < i_thresh.driving;
            r_crank_dip    <= i_avg < i_thresh.crank;
            r_over_voltage <= i_avg > i_thresh.overvolt;
        end
    end

    assign o_valid        = r_f_v;
    assign o_avg          = r_avg;
    assign o_low_comfort  = r_low_comfort;
    assign o_low_driving  = r_low_driving;
    assign o_crank_dip    = r_crank_dip;
    assign o_over_voltage = r_over_voltage;

endmodule

@@ hdl/battery_voltage_averager_unit.sv @@
// request path: input, product, quotient, window sum, mean and flag registers
// throughput: 1 request per cycle unless the output stalls; the running-sum
// update of the sample window (add newest, drop oldest) sets this rate
// reset: synchronous active low; window refilled with 12600 mV, sum with
// WINDOW * 12600, registers back to defaults, pipeline emptied
module battery_voltage_averager_unit
    import bva_pkg::*;
#(
    // window depth, 2 to 64
    parameter int WINDOW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes, no handshake
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    // request channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [SENSE_W-1:0]   i_sense_mv,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [DATA_W-1:0]    o_average_mv,
    output logic                 o_low_comfort,
    output logic                 o_low_driving,
    output logic                 o_crank_dip,
    output logic                 o_over_voltage
);

    // configuration registers
    logic [DATA_W-1:0] r_gain;
    t_thresh           r_thresh;

    // stage-to-stage handshakes
    logic              sc_valid, sc_ready;
    logic [DATA_W-1:0] sc_scaled;
    logic              win_valid, win_ready;
    logic [DATA_W-1:0] win_avg;

    // writes to unused indexes fall through and are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain            <= GAIN_RST;
            r_thresh.comfort  <= COMFORT_RST;
            r_thresh.driving  <= DRIVING_RST;
            r_thresh.crank    <= CRANK_RST;
            r_thresh.overvolt <= OVERVOLT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN:     r_gain            <= i_cfg_data;
                CFG_COMFORT:  r_thresh.comfort  <= i_cfg_data;
                CFG_DRIVING:  r_thresh.driving  <= i_cfg_data;
                CFG_CRANK:    r_thresh.crank    <= i_cfg_data;
                CFG_OVERVOLT: r_thresh.overvolt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register, gain multiply, divide by 1000 and clamp
    bva_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sense_mv (i_sense_mv),
        .i_gain     (r_gain),
        .o_valid    (sc_valid),
        .i_ready    (sc_ready),
        .o_scaled   (sc_scaled)
    );

    // sample window with running sum, then mean by reciprocal multiply
    bva_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sc_valid),
        .o_ready  (sc_ready),
        .i_scaled (sc_scaled),
        .o_valid  (win_valid),
        .i_ready  (win_ready),
        .o_avg    (win_avg)
    );

    // threshold compares into the output register
    bva_flags u_flags (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (win_valid),
        .o_ready        (win_ready),
        .i_avg          (win_avg),
        .i_thresh       (r_thresh),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_avg          (o_average_mv),
        .o_low_comfort  (o_low_comfort),
        .o_low_driving  (o_low_driving),
        .o_crank_dip    (o_crank_dip),
        .o_over_voltage (o_over_voltage)
    );

endmodule

@@ hdl/bva_checker.sv @@
`include "assert_macros.svh"

module bva_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_average_mv,
    input logic        o_low_comfort,
    input logic        o_over_voltage
);

    // reset empties the pipeline by the next edge
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

    // with nothing waiting at the output every stage can move
    `ASSERT_CLK(a_empty_ready, i_clk, i_rst_n, !o_valid |-> o_ready, "not ready while empty")

    // a stalled result holds
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n,
        o_valid && !i_ready |=> o_valid && $stable(o_average_mv) && $stable(o_low_comfort)
        && $stable(o_over_voltage), "stalled result changed")

endmodule

bind battery_voltage_averager_unit bva_checker u_bva_checker (.*);

@@ verif/tb_top.sv @@
// self-checking bench for the battery voltage averager
// a directed table runs first (reset values, field extremes, gain saturation,
// ignored register indexes, threshold equality); then random phases, each with
// new register values, random readings and constant runs that let the mean
// settle. every request goes through a local copy of the 8-deep window, and
// each result is compared with the oldest pending prediction
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bva_pkg::*;

    localparam int AVG_DEPTH      = 8;
    localparam int SCALE_DIV      = 1000;
    localparam int MAX_SCALED     = 65535;
    // request-to-result delay, used to pad the settling waits
    localparam int LATENCY        = 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_REQUESTS = 125;
    localparam int REPORT_LIMIT   = 10;

    // indexes past the register list, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] average_mv;
        logic              low_comfort;
        logic              low_driving;
        logic              crank_dip;
        logic              over_voltage;
    } t_avg_result;

    typedef enum logic {
        ROW_REQUEST,
        ROW_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    data;
        logic [SENSE_W-1:0]   sense;
        bit                   typed;
        t_avg_result          res;
    } t_row;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_LONG
    } t_rx_mode;

    // dut connections, all inputs known from time zero
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [DATA_W-1:0]    i_cfg_data = '0;
    logic                 i_valid    = 1'b0;
    logic                 o_ready;
    logic [SENSE_W-1:0]   i_sense_mv = '0;
    logic                 o_valid;
    logic                 i_ready    = 1'b0;
    logic [DATA_W-1:0]    o_average_mv;
    logic                 o_low_comfort;
    logic                 o_low_driving;
    logic                 o_crank_dip;
    logic                 o_over_voltage;

    // local copy of the block state
    logic [DATA_W-1:0] ring_mv [AVG_DEPTH];
    int unsigned       ring_slot;
    int unsigned       ring_total;
    logic [DATA_W-1:0] gain_x1000;
    t_thresh           thresh;

    t_avg_result pending_averages[$];
    int          mismatch_cnt = 0;
    bit          rst_done     = 1'b0;
    bit          idle_enable  = 1'b1;
    t_rx_mode    rx_mode      = RX_RANDOM;
    int          burst_left   = 0;

    battery_voltage_averager_unit #(
        .WINDOW(AVG_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sense_mv    (i_sense_mv),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_average_mv  (o_average_mv),
        .o_low_comfort (o_low_comfort),
        .o_low_driving (o_low_driving),
        .o_crank_dip   (o_crank_dip),
        .o_over_voltage(o_over_voltage)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // scale one reading, push it into the window, return the new mean and flags
    function automatic t_avg_result average_next(input logic [SENSE_W-1:0] mv);
        int unsigned prod;
        int unsigned scaled;
        int unsigned mean;
        t_avg_result r;
        prod   = 32'(mv) * 32'(gain_x1000);
        scaled = prod / SCALE_DIV;
        // saturate where a 16-bit cast would wrap
        if (scaled > MAX_SCALED) begin
            scaled = MAX_SCALED;
        end
        ring_total        = ring_total - ring_mv[ring_slot] + scaled;
        ring_mv[ring_slot] = scaled[DATA_W-1:0];
        ring_slot         = (ring_slot == AVG_DEPTH - 1) ? 0 : ring_slot + 1;
        mean              = ring_total / AVG_DEPTH;
        r.average_mv      = mean[DATA_W-1:0];
        // strict compares, a mean equal to a threshold raises nothing
        r.low_comfort     = mean < thresh.comfort;
        r.low_driving     = mean < thresh.driving;
        r.crank_dip       = mean < thresh.crank;
        r.over_voltage    = mean > thresh.overvolt;
        return r;
    endfunction

    function automatic t_row req_row(input logic [SENSE_W-1:0] mv);
        t_row r;
        r = '{kind: ROW_REQUEST, idx: '0, data: '0, sense: mv, typed: 1'b0, res: '0};
        return r;
    endfunction

    function automatic t_row req_checked(input logic [SENSE_W-1:0] mv,
                                         input t_avg_result res);
        t_row r;
        r = '{kind: ROW_REQUEST, idx: '0, data: '0, sense: mv, typed: 1'b1, res: res};
        return r;
    endfunction

    function automatic t_row write_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [DATA_W-1:0] data);
        t_row r;
        r = '{kind: ROW_WRITE, idx: idx, data: data, sense: '0, typed: 1'b0, res: '0};
        return r;
    endfunction

    // extremes, values near the present mean, a random value or a plausible battery level
    function automatic logic [DATA_W-1:0] pick_threshold();
        int unsigned level;
        level = ring_total / AVG_DEPTH;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'hFFFF;
            2, 3: return DATA_W'(level + $urandom_range(0, 4) - 2);
            4: return DATA_W'($urandom);
            default: return DATA_W'($urandom_range(8000, 20000));
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // wait until every predicted result has come out
    task automatic wait_drain();
        while (pending_averages.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // registers change only with the pipeline empty
    task automatic settle_block();
        i_valid    <= 1'b0;
        burst_left = 0;
        wait_drain();
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_GAIN:     gain_x1000      = data;
            CFG_COMFORT:  thresh.comfort  = data;
            CFG_DRIVING:  thresh.driving  = data;
            CFG_CRANK:    thresh.crank    = data;
            CFG_OVERVOLT: thresh.overvolt = data;
            default: ;
        endcase
    endtask

    // one request with burst pacing; valid stays high across back-to-back requests
    task automatic send_request(input logic [SENSE_W-1:0] mv, input bit typed,
                                input t_avg_result typed_res);
        int          gap;
        t_avg_result res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = idle_enable ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_sense_mv <= mv;
        do @(posedge i_clk); while (!o_ready);
        res = average_next(mv);
        pending_averages.push_back(typed ? typed_res : res);
    endtask

    // result side: check accepted results, then pick the next ready value
    always @(posedge i_clk) begin
        static int   rx_cnt  = 0;
        static int   rx_hold = 0;
        t_avg_result exp_res;
        if (rst_done && o_valid && i_ready) begin
            if (pending_averages.size() == 0) begin
                note_mismatch($sformatf("unexpected result avg=%0d", o_average_mv));
            end else begin
                exp_res = pending_averages.pop_front();
                if (o_average_mv !== exp_res.average_mv
                        || o_low_comfort !== exp_res.low_comfort
                        || o_low_driving !== exp_res.low_driving
                        || o_crank_dip !== exp_res.crank_dip
                        || o_over_voltage !== exp_res.over_voltage) begin
                    note_mismatch($sformatf(
                        "exp avg=%0d flags=%b%b%b%b got avg=%0d flags=%b%b%b%b",
                        exp_res.average_mv, exp_res.low_comfort, exp_res.low_driving,
                        exp_res.crank_dip, exp_res.over_voltage, o_average_mv,
                        o_low_comfort, o_low_driving, o_crank_dip, o_over_voltage));
                end
            end
        end
        rx_cnt++;
        case (rx_mode)
            RX_ALWAYS:   i_ready <= 1'b1;
            RX_RANDOM:   i_ready <= ($urandom_range(0, 9) >= 3);
            RX_PERIODIC: i_ready <= ((rx_cnt % 11) >= 3);
            default: begin
                // long stalls now and then
                if (rx_hold > 0) begin
                    rx_hold--;
                    i_ready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold = $urandom_range(1, 12);
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        endcase
    end

    // ends the run when nothing moves on either channel for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_done);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        t_row               directed[$];
        t_row_kind          last_kind;
        logic [SENSE_W-1:0] mv;
        logic [SENSE_W-1:0] run_mv;
        int                 run_left;

        // model state after reset
        for (int i = 0; i < AVG_DEPTH; i++) begin
            ring_mv[i] = NOMINAL_MV;
        end
        ring_slot  = 0;
        ring_total = AVG_DEPTH * NOMINAL_MV;
        gain_x1000 = GAIN_RST;
        thresh     = '{comfort: COMFORT_RST, driving: DRIVING_RST,
                       crank: CRANK_RST, overvolt: OVERVOLT_RST};

        // reset window, defaults: 0 mV gives (7 * 12600) / 8
        directed.push_back(req_checked(12'd0, '{16'd11025, 1'b1, 1'b1, 1'b0, 1'b0}));
        // full-scale reading: 4095 * 5700 / 1000 = 23341
        directed.push_back(req_checked(12'd4095, '{16'd12367, 1'b0, 1'b0, 1'b0, 1'b0}));
        directed.push_back(req_row(12'd3300));
        directed.push_back(req_row(12'd1));
        directed.push_back(req_row(12'd2730));
        directed.push_back(req_row(12'd1365));
        directed.push_back(req_row(12'd4000));
        // largest gain, scaled value saturates
        directed.push_back(write_row(CFG_GAIN, 16'hFFFF));
        directed.push_back(req_row(12'd4095));
        directed.push_back(req_row(12'd0));
        // zero gain and a gain below unity
        directed.push_back(write_row(CFG_GAIN, 16'd0));
        directed.push_back(req_row(12'd2048));
        directed.push_back(req_row(12'd4095));
        directed.push_back(write_row(CFG_GAIN, 16'd999));
        directed.push_back(req_row(12'd1));
        directed.push_back(req_row(12'd3300));
        // writes past the register list leave the gain alone
        directed.push_back(write_row(CFG_SPARE_LO, 16'd0));
        directed.push_back(write_row(CFG_SPARE_HI, 16'hFFFF));
        directed.push_back(req_row(12'd3300));
        // unity gain, all thresholds at 1000, then settle the mean on 1000
        directed.push_back(write_row(CFG_GAIN, 16'd1000));
        directed.push_back(write_row(CFG_COMFORT, 16'd1000));
        directed.push_back(write_row(CFG_DRIVING, 16'd1000));
        directed.push_back(write_row(CFG_CRANK, 16'd1000));
        directed.push_back(write_row(CFG_OVERVOLT, 16'd1000));
        repeat (7) directed.push_back(req_row(12'd1000));
        // mean equal to every threshold: no flag
        directed.push_back(req_checked(12'd1000, '{16'd1000, 1'b0, 1'b0, 1'b0, 1'b0}));
        // one below: every low flag
        directed.push_back(req_checked(12'd999, '{16'd999, 1'b1, 1'b1, 1'b1, 1'b0}));
        directed.push_back(req_row(12'd1001));
        directed.push_back(req_row(12'd1010));

        // single reset at the start
        repeat (8) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;
        @(posedge i_clk);

        // directed table
        last_kind = ROW_REQUEST;
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_WRITE) begin
                if (last_kind == ROW_REQUEST) begin
                    settle_block();
                end
                write_register(directed[i].idx, directed[i].data);
            end else begin
                if (last_kind == ROW_WRITE) begin
                    i_cfg_we <= 1'b0;
                end
                send_request(directed[i].sense, directed[i].typed, directed[i].res);
            end
            last_kind = directed[i].kind;
        end

        // random phases, new register values each time
        run_left = 0;
        run_mv   = '0;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            settle_block();
            case ($urandom_range(0, 9))
                0: write_register(CFG_GAIN, 16'hFFFF);
                1: write_register(CFG_GAIN, 16'd1000);
                2: write_register(CFG_GAIN, DATA_W'($urandom_range(0, 999)));
                3: write_register(CFG_GAIN, DATA_W'($urandom_range(1000, 65535)));
                default: write_register(CFG_GAIN, DATA_W'($urandom_range(3000, 8000)));
            endcase
            write_register(CFG_COMFORT, pick_threshold());
            write_register(CFG_DRIVING, pick_threshold());
            write_register(CFG_CRANK, pick_threshold());
            write_register(CFG_OVERVOLT, pick_threshold());
            if ($urandom_range(0, 3) == 0) begin
                write_register(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                               DATA_W'($urandom));
            end
            i_cfg_we    <= 1'b0;
            // one phase in four runs the sender with no gaps
            idle_enable = (phase % 4 != 1);
            rx_mode     = t_rx_mode'(phase % 4);

            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // hold off once mid-phase until the output side is empty
                if (phase == 2 && n == PHASE_REQUESTS / 2) begin
                    i_valid    <= 1'b0;
                    burst_left = 0;
                    wait_drain();
                end
                if (run_left == 0 && $urandom_range(0, 9) == 0) begin
                    // constant run, the mean settles on one value
                    run_left = $urandom_range(8, 16);
                    run_mv   = SENSE_W'($urandom_range(0, 3300));
                end
                if (run_left > 0) begin
                    run_left--;
                    mv = run_mv;
                end else if ($urandom_range(0, 6) == 0) begin
                    mv = SENSE_W'($urandom_range(0, 4095));
                end else begin
                    mv = SENSE_W'($urandom_range(0, 3300));
                end
                send_request(mv, 1'b0, '0);
            end
        end

        // let the tail drain, then allow for stray results
        i_valid <= 1'b0;
        wait_drain();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_averages.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bva_pkg.sv
hdl/bva_scale.sv
hdl/bva_window.sv
hdl/bva_flags.sv
hdl/battery_voltage_averager_unit.sv
hdl/bva_checker.sv
verif/tb_top.sv
